// ===== hw/rtl/lgp_pkg.sv =====
// ----------------------------------------------------------------------------
// lgp_pkg: shared types and constants for the linear gradient pixel block
// Field widths, register codes, direction codes and channel layout.
// ----------------------------------------------------------------------------
package lgp_pkg;

  localparam int MAX_DIM_DEF = 4096;

  localparam int PIX_W       = 12;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 4;
  localparam int COLOR_W     = CH_W * NUM_CH;
  localparam int DIM_REG_W   = 13;
  localparam int DIM_REG_MAX = (2 ** DIM_REG_W) - 1;
  localparam int DIR_W       = 2;

  localparam int IN_DATA_W   = 2 * PIX_W;
  localparam int OUT_DATA_W  = COLOR_W;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = COLOR_W;

  typedef enum logic [DIR_W-1:0] {
    DIR_VERT  = 2'd0,
    DIR_HORZ  = 2'd1,
    DIR_RDIAG = 2'd2,
    DIR_LDIAG = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_COLOR = 3'd0,
    REG_END_COLOR   = 3'd1,
    REG_WIDTH       = 3'd2,
    REG_HEIGHT      = 3'd3,
    REG_DIRECTION   = 3'd4
  } cfg_reg_t;

endpackage

// ===== hw/rtl/lgp_div.sv =====
// ----------------------------------------------------------------------------
// lgp_div: pipelined restoring divider, four channels side by side
// One quotient bit per stage, most significant first; the last stage is the
// output register. Each stage holds its beat until the next one can take it.
// ----------------------------------------------------------------------------
module lgp_div #(
  parameter int DVW  = 34,
  parameter int DSRW = 26
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [lgp_pkg::NUM_CH-1:0][DVW-1:0]           in_dvd,
  input  logic [DSRW-1:0]                               in_dsr,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [lgp_pkg::NUM_CH-1:0][lgp_pkg::CH_W-1:0] out_q
);
  import lgp_pkg::*;

  localparam int NS = CH_W;

  logic [NS-1:0]                    v_r;
  logic [NS-1:0]                    v_nxt;
  logic [NS:0]                      rdy;
  logic [NUM_CH-1:0][DVW-1:0]       rem_r [NS-1];
  logic [DSRW-1:0]                  dsr_r [NS-1];
  logic [NUM_CH-1:0][CH_W-1:0]      q_r   [NS];

  always_comb begin
    rdy[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
    for (int s = 0; s < NS; s++) begin
      v_nxt[s] = (s == 0) ? in_valid : v_r[(s == 0) ? 0 : s - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_nxt[s];
        end
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [NUM_CH-1:0][DVW-1:0]  src_rem;
    logic [DSRW-1:0]             src_dsr;
    logic [NUM_CH-1:0][CH_W-1:0] src_q;
    logic [DVW-1:0]              shd;
    logic [NUM_CH-1:0][DVW:0]    diff;
    logic [NUM_CH-1:0]           fits;
    logic [NUM_CH-1:0][CH_W-1:0] q_nxt;

    if (s == 0) begin : g_first
      assign src_rem = in_dvd;
      assign src_dsr = in_dsr;
      assign src_q   = '0;
    end else begin : g_rest
      assign src_rem = rem_r[s-1];
      assign src_dsr = dsr_r[s-1];
      assign src_q   = q_r[s-1];
    end

    assign shd = DVW'(src_dsr) << (NS - 1 - s);

    always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
        diff[c]  = {1'b0, src_rem[c]} - {1'b0, shd};
        fits[c]  = !diff[c][DVW];
        q_nxt[c] = {src_q[c][CH_W-2:0], fits[c]};
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        q_r[s] <= q_nxt;
      end
    end

    if (s < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          for (int c = 0; c < NUM_CH; c++) begin
            rem_r[s][c] <= fits[c] ? diff[c][DVW-1:0] : src_rem[c];
          end
          dsr_r[s] <= src_dsr;
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_q     = q_r[NS-1];

endmodule

// ===== hw/rtl/linear_gradient_pixel.sv =====
// ----------------------------------------------------------------------------
// linear_gradient_pixel: colour of one pixel in a two-colour linear gradient
// Takes a pixel coordinate and returns its RGBA colour, each channel being
// start + (end - start) * fraction, rounded half up, computed exactly.
// ----------------------------------------------------------------------------
// The block takes one coordinate beat per clock while in_tready is high, and
// returns one colour beat per coordinate, in order. Register stages clamp
// the coordinate, form the fraction's numerator and denominator and weight
// the two colours, then a one-bit-per-stage restoring divider produces each
// 8-bit channel. Bubbles close up behind a stalled output, so input is
// still taken until every stage holds a beat. The user must write registers
// through the cfg_ port only while no pixel is in flight; the block does
// not enforce this. The width and height are clamped to 1 .. MAX_DIM and
// coordinates beyond the image are clamped to its edge.
// ----------------------------------------------------------------------------
module linear_gradient_pixel #(
  parameter int MAX_DIM = lgp_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lgp_pkg::IN_DATA_W-1:0]    in_tdata,   // pixel_x, pixel_y
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lgp_pkg::OUT_DATA_W-1:0]   out_tdata,  // red, green, blue, alpha
  input  logic                             cfg_we,
  input  logic [lgp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lgp_pkg::*;

  localparam int EFF_MAX = (MAX_DIM > DIM_REG_MAX) ? DIM_REG_MAX : MAX_DIM;
  localparam int DW      = $clog2(EFF_MAX);
  localparam int CW      = (DW > PIX_W) ? DW : PIX_W;
  localparam int PW      = 2 * DW;
  localparam int DENW    = PW + 1;
  localparam int ACCW    = DENW + CH_W;
  localparam int DVW     = ACCW + 1;
  localparam int DSRW    = DENW + 1;
  localparam int FS      = 5;

  logic [COLOR_W-1:0]   start_color_r;
  logic [COLOR_W-1:0]   end_color_r;
  logic [DIM_REG_W-1:0] width_r;
  logic [DIM_REG_W-1:0] height_r;
  dir_t                 dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_color_r <= '0;
      end_color_r   <= '1;
      width_r       <= DIM_REG_W'(1);
      height_r      <= DIM_REG_W'(1);
      dir_r         <= DIR_VERT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_COLOR: start_color_r <= cfg_wdata[COLOR_W-1:0];
        REG_END_COLOR:   end_color_r   <= cfg_wdata[COLOR_W-1:0];
        REG_WIDTH:       width_r       <= cfg_wdata[DIM_REG_W-1:0];
        REG_HEIGHT:      height_r      <= cfg_wdata[DIM_REG_W-1:0];
        REG_DIRECTION:   dir_r         <= dir_t'(cfg_wdata[DIR_W-1:0]);
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] dim_m1(input logic [DIM_REG_W-1:0] v);
    logic [DIM_REG_W-1:0] e;
    e = v;
    if (v == '0) begin
      e = DIM_REG_W'(1);
    end else if (32'(v) > 32'(EFF_MAX)) begin
      e = DIM_REG_W'(EFF_MAX);
    end
    return DW'(e - DIM_REG_W'(1));
  endfunction

  // pipeline control
  logic [FS-1:0] v_r;
  logic [FS:0]   rdy;
  logic          div_in_ready;

  always_comb begin
    rdy[FS] = div_in_ready;
    for (int k = FS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < FS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready = rdy[0];

  // stage 1: clamp, mirror, axis terms
  logic [PIX_W-1:0] px, py;
  logic [DW-1:0]    wm1, hm1, xc, yc, xm, ym;
  logic [DW-1:0]    nx1_nxt, ny1_nxt, dx1_nxt, dy1_nxt;
  logic [DW-1:0]    nx1_r, ny1_r, dx1_r, dy1_r;
  dir_t             dir1_r;

  always_comb begin
    px  = in_tdata[PIX_W-1:0];
    py  = in_tdata[2*PIX_W-1:PIX_W];
    wm1 = dim_m1(width_r);
    hm1 = dim_m1(height_r);
    xc  = (CW'(px) > CW'(wm1)) ? wm1 : DW'(px);
    yc  = (CW'(py) > CW'(hm1)) ? hm1 : DW'(py);
    xm  = (dir_r == DIR_LDIAG) ? wm1 - xc : xc;
    ym  = (dir_r == DIR_LDIAG) ? hm1 - yc : yc;
    nx1_nxt = (wm1 == '0) ? '0 : xm;
    dx1_nxt = (wm1 == '0) ? DW'(1) : wm1;
    ny1_nxt = (hm1 == '0) ? '0 : ym;
    dy1_nxt = (hm1 == '0) ? DW'(1) : hm1;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      nx1_r  <= nx1_nxt;
      ny1_r  <= ny1_nxt;
      dx1_r  <= dx1_nxt;
      dy1_r  <= dy1_nxt;
      dir1_r <= dir_r;
    end
  end

  // stage 2: cross products
  logic [DW-1:0] nlin2_r, dlin2_r;
  logic [PW-1:0] pxy2_r, pyx2_r, pd2_r;
  logic          diag2_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      nlin2_r <= (dir1_r == DIR_VERT) ? ny1_r : nx1_r;
      dlin2_r <= (dir1_r == DIR_VERT) ? dy1_r : dx1_r;
      pxy2_r  <= PW'(nx1_r) * PW'(dy1_r);
      pyx2_r  <= PW'(ny1_r) * PW'(dx1_r);
      pd2_r   <= PW'(dx1_r) * PW'(dy1_r);
      diag2_r <= (dir1_r == DIR_RDIAG) || (dir1_r == DIR_LDIAG);
    end
  end

  // stage 3: numerator and denominator
  logic [DENW-1:0] num3_r, den3_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      num3_r <= diag2_r ? DENW'(pxy2_r) + DENW'(pyx2_r) : DENW'(nlin2_r);
      den3_r <= diag2_r ? {pd2_r, 1'b0} : DENW'(dlin2_r);
    end
  end

  // stage 4: colour weighting
  logic [NUM_CH-1:0][ACCW-1:0] ps4_r, pe4_r;
  logic [DENW-1:0]             den4_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        ps4_r[c] <= ACCW'(start_color_r[COLOR_W-1-CH_W*c -: CH_W])
                    * ACCW'(den3_r - num3_r);
        pe4_r[c] <= ACCW'(end_color_r[COLOR_W-1-CH_W*c -: CH_W]) * ACCW'(num3_r);
      end
      den4_r <= den3_r;
    end
  end

  // stage 5: dividend with half-up rounding term
  logic [NUM_CH-1:0][DVW-1:0] dvd5_r;
  logic [DSRW-1:0]            dsr5_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        dvd5_r[c] <= {ps4_r[c] + pe4_r[c], 1'b0} + DVW'(den4_r);
      end
      dsr5_r <= {den4_r, 1'b0};
    end
  end

  logic [NUM_CH-1:0][CH_W-1:0] q;

  lgp_div #(
    .DVW  (DVW),
    .DSRW (DSRW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[FS-1]),
    .in_ready  (div_in_ready),
    .in_dvd    (dvd5_r),
    .in_dsr    (dsr5_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_q     (q)
  );

  assign out_tdata = q;

  logic dvd_in_range;

  always_comb begin
    dvd_in_range = 1'b1;
    for (int c = 0; c < NUM_CH; c++) begin
      if ((dvd5_r[c] >> CH_W) >= DVW'(dsr5_r)) begin
        dvd_in_range = 1'b0;
      end
    end
  end

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> den3_r != '0)
    else $error("zero denominator in flight");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> num3_r <= den3_r)
    else $error("fraction above one");

  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[FS-1] |-> dvd_in_range)
    else $error("quotient would overflow a channel");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && !div_in_ready)
    else $error("input stalled with a free stage");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted beat not held in first stage");

endmodule

// ===== tb/sv/linear_gradient_pixel_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_gradient_pixel_tb: self-checking regression for the gradient pixel
// Drives coordinate beats into the block under a range of colour, size and
// direction settings. Each colour is predicted in exact integer arithmetic
// and checked channel by channel. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module linear_gradient_pixel_tb;
  import lgp_pkg::*;

  localparam int MAX_DIM     = MAX_DIM_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;
  localparam int RAND_ITEMS  = 850;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_DIRECTION + 1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } colour_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [COLOR_W-1:0]   cur_start;
  logic [COLOR_W-1:0]   cur_end;
  logic [DIM_REG_W-1:0] cur_width;
  logic [DIM_REG_W-1:0] cur_height;
  dir_t                 cur_dir;

  colour_t colours_due[$];
  bit      gaps_on;
  int      n_errors;
  int      n_pixels;
  int      n_colours;
  int      n_setups;
  int      n_cycles;

  linear_gradient_pixel #(.MAX_DIM(MAX_DIM)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned eff_dim(input logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 64'(v);
  endfunction

  function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] s, input logic [CH_W-1:0] e,
                                             input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned acc;
    acc = s * (den - num) + e * num;
    return CH_W'((2 * acc + den) / (2 * den));
  endfunction

  function automatic colour_t gradient_colour(input logic [PIX_W-1:0] px,
                                              input logic [PIX_W-1:0] py);
    longint unsigned w, h, x, y, dx, dy, nx, ny, num, den;
    colour_t c;
    w = eff_dim(cur_width);
    h = eff_dim(cur_height);
    x = (64'(px) > w - 1) ? w - 1 : 64'(px);
    y = (64'(py) > h - 1) ? h - 1 : 64'(py);
    if (cur_dir == DIR_LDIAG) begin
      x = (w - 1) - x;
      y = (h - 1) - y;
    end
    if (w > 1) begin dx = w - 1; nx = x; end else begin dx = 1; nx = 0; end
    if (h > 1) begin dy = h - 1; ny = y; end else begin dy = 1; ny = 0; end
    case (cur_dir)
      DIR_VERT: begin num = ny; den = dy; end
      DIR_HORZ: begin num = nx; den = dx; end
      default:  begin num = nx * dy + ny * dx; den = 2 * dx * dy; end
    endcase
    c.red   = blend(cur_start[31:24], cur_end[31:24], num, den);
    c.green = blend(cur_start[23:16], cur_end[23:16], num, den);
    c.blue  = blend(cur_start[15:8],  cur_end[15:8],  num, den);
    c.alpha = blend(cur_start[7:0],   cur_end[7:0],   num, den);
    return c;
  endfunction

  // hold cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_START_COLOR: cur_start  = val;
      REG_END_COLOR:   cur_end    = val;
      REG_WIDTH:       cur_width  = val[DIM_REG_W-1:0];
      REG_HEIGHT:      cur_height = val[DIM_REG_W-1:0];
      REG_DIRECTION:   cur_dir    = dir_t'(val[DIR_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_gradient(input logic [COLOR_W-1:0] s, input logic [COLOR_W-1:0] e,
                              input logic [DIM_REG_W-1:0] w, input logic [DIM_REG_W-1:0] h,
                              input dir_t d);
    write_reg(REG_START_COLOR, s);
    write_reg(REG_END_COLOR, e);
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_DIRECTION, CFG_DATA_W'(d));
    cfg_we <= 1'b0;
    @(posedge clk);
    n_setups++;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    int gap;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px};
    colours_due.insert(colours_due.size(), gradient_colour(px, py));
    n_pixels++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (colours_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic test_reset_state;
    send_pixel('0, '0);
    send_pixel('1, '1);
    drain();
  endtask

  task automatic test_directions;
    for (int d = 0; d < 4; d++) begin
      set_gradient(32'h1020_4080, 32'hF0E0_C000, 13'd5, 13'd3, dir_t'(d));
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4, 12'd2);
      send_pixel(12'd3, 12'd1);
      drain();
    end
  endtask

  task automatic test_full_extent;
    set_gradient(32'h00FF_00FF, 32'hFF00_FF00, DIM_REG_W'(MAX_DIM), DIM_REG_W'(MAX_DIM),
                 DIR_RDIAG);
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel('1, '0);
    send_pixel(12'd2048, 12'd2047);
    drain();
  endtask

  task automatic test_odd_sizes;
    set_gradient(32'h0000_0000, 32'hFFFF_FFFF, 13'd0, 13'h1FFF, DIR_HORZ);
    send_pixel('1, '1);
    drain();
    set_gradient(32'h8040_2010, 32'h0102_0408, 13'd1, 13'd2, DIR_LDIAG);
    send_pixel(12'd0, 12'd0);
    drain();
    set_gradient(32'h0000_0000, 32'hFFFF_FFFF, 13'd7, 13'd9, DIR_VERT);
    send_pixel('1, '1);
    drain();
  endtask

  task automatic test_half_rounding;
    set_gradient(32'h0000_0000, 32'h0101_0101, 13'd3, 13'd1, DIR_HORZ);
    send_pixel(12'd1, 12'd0);
    drain();
  endtask

  task automatic test_spare_index;
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      write_reg(i[CFG_IDX_W-1:0], $urandom());
    cfg_we <= 1'b0;
    @(posedge clk);
    send_pixel(12'd2, 12'd0);
    drain();
  endtask

  function automatic logic [COLOR_W-1:0] pick_colour();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DIM_REG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return DIM_REG_W'(1);
      1:       return DIM_REG_W'(2);
      2:       return DIM_REG_W'(MAX_DIM);
      3:       return '0;
      4:       return DIM_REG_W'($urandom_range(MAX_DIM + 1, DIM_REG_MAX));
      5, 6:    return DIM_REG_W'($urandom_range(1, MAX_DIM));
      default: return DIM_REG_W'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic test_random_fills;
    int burst;
    int lim_x;
    int lim_y;
    while (n_pixels < RAND_ITEMS) begin
      set_gradient(pick_colour(), pick_colour(), pick_dim(), pick_dim(),
                   dir_t'($urandom_range(0, 3)));
      gaps_on = ($urandom_range(0, 3) != 0);
      lim_x   = int'(eff_dim(cur_width) - 1);
      lim_y   = int'(eff_dim(cur_height) - 1);
      burst   = $urandom_range(20, 70);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 6)
          send_pixel(PIX_W'($urandom_range(0, lim_x)), PIX_W'($urandom_range(0, lim_y)));
        else
          send_pixel(PIX_W'($urandom()), PIX_W'($urandom()));
      end
      drain();
    end
  endtask

  task automatic check_channel(input string name, input logic [CH_W-1:0] exp_v,
                               input logic [CH_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    colour_t want;
    colour_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = colour_t'(out_tdata);
      if (colours_due.size() == 0) begin
        $display("%0t: unexpected colour beat, expected none, got %h", $time, out_tdata);
        n_errors++;
      end else begin
        want = colours_due.pop_front();
        check_channel("red", want.red, got.red);
        check_channel("green", want.green, got.green);
        check_channel("blue", want.blue, got.blue);
        check_channel("alpha", want.alpha, got.alpha);
        n_colours++;
      end
    end
  end

  initial begin : sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d colours outstanding", $time, colours_due.size());
      $display("linear_gradient_pixel regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_START_COLOR;
    cfg_wdata  <= '0;
    cur_start  = '0;
    cur_end    = '1;
    cur_width  = DIM_REG_W'(1);
    cur_height = DIM_REG_W'(1);
    cur_dir    = DIR_VERT;
    gaps_on    = 1'b1;
    n_errors   = 0;
    n_pixels   = 0;
    n_colours  = 0;
    n_setups   = 0;
    n_cycles   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directions();
    test_full_extent();
    test_odd_sizes();
    test_half_rounding();
    test_spare_index();
    test_random_fills();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (colours_due.size() != 0) begin
      $display("%0t: %0d colours never arrived", $time, colours_due.size());
      n_errors++;
    end
    $display("Checked %0d colours from %0d pixels across %0d gradient setups, %0d errors.",
             n_colours, n_pixels, n_setups, n_errors);
    $display("All four directions, unit and oversized dimensions, clamping and idle gaps seen.");
    if (n_errors == 0)
      $display("linear_gradient_pixel regression: pass");
    else
      $display("linear_gradient_pixel regression: fail");
    $finish;
  end

endmodule

// ===== linear_gradient_pixel.f =====
hw/rtl/lgp_pkg.sv
hw/rtl/lgp_div.sv
hw/rtl/linear_gradient_pixel.sv
tb/sv/linear_gradient_pixel_tb.sv
